// File: hw/rtl/asdfp_pkg.sv
package asdfp_pkg;

  localparam int unsigned FRACTION_DIGITS_DEFAULT = 3;
  localparam int unsigned INT_W = 32;
  localparam int unsigned VALUE_W = 32;

  localparam logic [7:0] START_CHAR_RESET = 8'd58;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;
  localparam logic [7:0] ASCII_POINT = 8'h2E;
  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_NINE = 8'h39;

  localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_FIRST  = 2'd1,
    MODE_NUMBER = 2'd2
  } mode_t;

  function automatic logic [63:0] pow10(input int unsigned n);
    logic [63:0] p;
    p = 64'd1;
    for (int unsigned k = 0; k < 19; k++) begin
      if (k < n) begin
        p = p * 64'd10;
      end
    end
    return p;
  endfunction

endpackage

// File: hw/rtl/asdfp_if.sv
interface asdfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_packet;

  modport source(output valid, output in_byte, output end_of_packet, input ready);
  modport sink(input valid, input in_byte, input end_of_packet, output ready);
endinterface

interface asdfp_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value_milli;
  logic               had_digits;

  modport source(output valid, output value_milli, output had_digits, input ready);
  modport sink(input valid, input value_milli, input had_digits, output ready);
endinterface

// File: hw/rtl/asdfp_scan.sv
module asdfp_scan #(
  parameter int unsigned FRACTION_DIGITS = asdfp_pkg::FRACTION_DIGITS_DEFAULT,
  localparam int unsigned FRAC_W = $clog2(asdfp_pkg::pow10(FRACTION_DIGITS))
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [7:0]                  start_char,
  asdfp_byte_if.sink                  stream,
  output logic                        snap_valid,
  input  logic                        snap_ready,
  output logic                        snap_negative,
  output logic                        snap_digits,
  output logic [asdfp_pkg::INT_W-1:0] snap_integer,
  output logic [FRAC_W-1:0]           snap_fraction
);

  localparam int unsigned CNT_W = $clog2(FRACTION_DIGITS + 1);
  localparam int unsigned IDX_W = (FRACTION_DIGITS > 1) ? $clog2(FRACTION_DIGITS) : 1;
  localparam int unsigned IW = asdfp_pkg::INT_W;

  asdfp_pkg::mode_t mode, mode_next;
  logic             negative, negative_next;
  logic             point_seen, point_seen_next;
  logic             digit_seen, digit_seen_next;
  logic [IW-1:0]    integer_acc, integer_acc_next;
  logic [FRAC_W-1:0] fraction_acc, fraction_acc_next;
  logic [CNT_W-1:0] frac_count, frac_count_next;
  logic             emit;
  logic             accept;
  logic             is_digit;
  logic [3:0]       digit;
  logic [IW+3:0]    int_times10;
  logic [IW+3:0]    int_sum;
  logic [FRAC_W+3:0] frac_step;
  logic [FRAC_W-1:0] weight [FRACTION_DIGITS];

  for (genvar i = 0; i < FRACTION_DIGITS; i++) begin : g_weight
    assign weight[i] = FRAC_W'(asdfp_pkg::pow10(FRACTION_DIGITS - 1 - i));
  end

  assign stream.ready = !snap_valid || snap_ready;
  assign accept = stream.valid && stream.ready;

  assign is_digit = stream.in_byte inside {[asdfp_pkg::ASCII_ZERO:asdfp_pkg::ASCII_NINE]};
  assign digit = 4'(stream.in_byte - asdfp_pkg::ASCII_ZERO);
  assign int_times10 = {1'b0, integer_acc, 3'b000} + {3'b000, integer_acc, 1'b0};
  assign int_sum = int_times10 + (IW + 4)'(digit);
  assign frac_step = (FRAC_W + 4)'(weight[frac_count[IDX_W-1:0]]) * (FRAC_W + 4)'(digit);

  always_comb begin
    mode_next = mode;
    negative_next = negative;
    point_seen_next = point_seen;
    digit_seen_next = digit_seen;
    integer_acc_next = integer_acc;
    fraction_acc_next = fraction_acc;
    frac_count_next = frac_count;
    emit = 1'b0;
    case (mode)
      asdfp_pkg::MODE_FIRST, asdfp_pkg::MODE_NUMBER: begin
        if (mode == asdfp_pkg::MODE_FIRST && stream.in_byte == asdfp_pkg::ASCII_MINUS) begin
          negative_next = 1'b1;
          mode_next = asdfp_pkg::MODE_NUMBER;
        end else if (is_digit) begin
          mode_next = asdfp_pkg::MODE_NUMBER;
          digit_seen_next = 1'b1;
          if (point_seen) begin
            if (frac_count < CNT_W'(FRACTION_DIGITS)) begin
              fraction_acc_next = fraction_acc + frac_step[FRAC_W-1:0];
              frac_count_next = frac_count + CNT_W'(1);
            end
          end else if (int_sum > (IW + 4)'({IW{1'b1}})) begin
            integer_acc_next = {IW{1'b1}};
          end else begin
            integer_acc_next = int_sum[IW-1:0];
          end
        end else if (stream.in_byte == asdfp_pkg::ASCII_POINT) begin
          mode_next = asdfp_pkg::MODE_NUMBER;
          point_seen_next = 1'b1;
        end else begin
          emit = 1'b1;
        end
        if (stream.end_of_packet) begin
          emit = 1'b1;
        end
      end
      default: begin
        mode_next = asdfp_pkg::MODE_IDLE;
        if (stream.in_byte == start_char) begin
          mode_next = asdfp_pkg::MODE_FIRST;
          negative_next = 1'b0;
          point_seen_next = 1'b0;
          digit_seen_next = 1'b0;
          integer_acc_next = '0;
          fraction_acc_next = '0;
          frac_count_next = '0;
          emit = stream.end_of_packet;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= asdfp_pkg::MODE_IDLE;
      negative <= 1'b0;
      point_seen <= 1'b0;
      digit_seen <= 1'b0;
      integer_acc <= '0;
      fraction_acc <= '0;
      frac_count <= '0;
    end else if (accept) begin
      if (emit) begin
        mode <= asdfp_pkg::MODE_IDLE;
        negative <= 1'b0;
        point_seen <= 1'b0;
        digit_seen <= 1'b0;
        integer_acc <= '0;
        fraction_acc <= '0;
        frac_count <= '0;
      end else begin
        mode <= mode_next;
        negative <= negative_next;
        point_seen <= point_seen_next;
        digit_seen <= digit_seen_next;
        integer_acc <= integer_acc_next;
        fraction_acc <= fraction_acc_next;
        frac_count <= frac_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (accept && emit) begin
      snap_valid <= 1'b1;
    end else if (snap_ready) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      snap_negative <= negative_next;
      snap_digits <= digit_seen_next;
      snap_integer <= integer_acc_next;
      snap_fraction <= fraction_acc_next;
    end
  end

endmodule

// File: hw/rtl/asdfp_scale.sv
module asdfp_scale #(
  parameter int unsigned FRACTION_DIGITS = asdfp_pkg::FRACTION_DIGITS_DEFAULT,
  localparam int unsigned FRAC_W = $clog2(asdfp_pkg::pow10(FRACTION_DIGITS))
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        snap_valid,
  output logic                        snap_ready,
  input  logic                        snap_negative,
  input  logic                        snap_digits,
  input  logic [asdfp_pkg::INT_W-1:0] snap_integer,
  input  logic [FRAC_W-1:0]           snap_fraction,
  asdfp_result_if.source              result
);

  localparam int unsigned PROD_W = asdfp_pkg::INT_W + FRAC_W;
  localparam int unsigned SUM_W = PROD_W + 1;
  localparam int unsigned VW = asdfp_pkg::VALUE_W;
  localparam logic [FRAC_W-1:0] SCALE = FRAC_W'(asdfp_pkg::pow10(FRACTION_DIGITS));

  logic              prod_valid;
  logic [PROD_W-1:0] prod;
  logic [FRAC_W-1:0] prod_fraction;
  logic              prod_negative;
  logic              prod_digits;
  logic              out_advance;
  logic [SUM_W-1:0]  sum;
  logic [VW-1:0]     word;

  assign out_advance = !result.valid || result.ready;
  assign snap_ready = !prod_valid || out_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (snap_ready) begin
      prod_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_ready && snap_valid) begin
      prod <= PROD_W'(snap_integer) * PROD_W'(SCALE);
      prod_fraction <= snap_fraction;
      prod_negative <= snap_negative;
      prod_digits <= snap_digits;
    end
  end

  assign sum = SUM_W'(prod) + SUM_W'(prod_fraction);

  always_comb begin
    if (prod_negative) begin
      if (sum > SUM_W'(asdfp_pkg::VALUE_MAX)) begin
        word = asdfp_pkg::VALUE_MIN;
      end else begin
        word = VW'(0) - sum[VW-1:0];
      end
    end else if (sum > SUM_W'(asdfp_pkg::VALUE_MAX)) begin
      word = asdfp_pkg::VALUE_MAX;
    end else begin
      word = sum[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_advance) begin
      result.valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_advance && prod_valid) begin
      result.value_milli <= signed'(word);
      result.had_digits <= prod_digits;
    end
  end

endmodule

// File: hw/rtl/ascii_signed_decimal_field_parser_core.sv
// Parses signed decimal number fields out of a byte stream. A byte equal to the
// start character opens a field; an optional minus sign may follow at once, then
// digits with an optional decimal point. The first other byte closes the field and
// is consumed, and the last byte of a packet closes an open field after it has been
// applied. Each closed field yields one beat carrying the value scaled by ten to the
// power FRACTION_DIGITS, with extra fraction digits truncated and the result
// saturated to 32 bits, plus a flag telling whether any digit was seen. One byte
// is taken in every cycle while the result side keeps up; the scanning logic
// updates its accumulators in the cycle a byte is accepted. A result passes through three
// registers after the byte that closed its field: a field register, a register after
// the integer scaling multiplier, and the saturating output register.
module ascii_signed_decimal_field_parser_core #(
  parameter int unsigned FRACTION_DIGITS = asdfp_pkg::FRACTION_DIGITS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  asdfp_byte_if.sink     stream,
  asdfp_result_if.source result,
  input  logic           cfg_we,
  input  logic [7:0]     cfg_wdata
);

  localparam int unsigned FRAC_W = $clog2(asdfp_pkg::pow10(FRACTION_DIGITS));

  logic                        start_char;
  logic [7:0]                  start_char_reg;
  logic                        snap_valid;
  logic                        snap_ready;
  logic                        snap_negative;
  logic                        snap_digits;
  logic [asdfp_pkg::INT_W-1:0] snap_integer;
  logic [FRAC_W-1:0]           snap_fraction;

  assign start_char = start_char_reg == stream.in_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_char_reg <= asdfp_pkg::START_CHAR_RESET;
    end else if (cfg_we) begin
      start_char_reg <= cfg_wdata;
    end
  end

  asdfp_scan #(
    .FRACTION_DIGITS(FRACTION_DIGITS)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .start_char   (start_char_reg),
    .stream       (stream),
    .snap_valid   (snap_valid),
    .snap_ready   (snap_ready),
    .snap_negative(snap_negative),
    .snap_digits  (snap_digits),
    .snap_integer (snap_integer),
    .snap_fraction(snap_fraction)
  );

  asdfp_scale #(
    .FRACTION_DIGITS(FRACTION_DIGITS)
  ) u_scale (
    .clk          (clk),
    .rst          (rst),
    .snap_valid   (snap_valid),
    .snap_ready   (snap_ready),
    .snap_negative(snap_negative),
    .snap_digits  (snap_digits),
    .snap_integer (snap_integer),
    .snap_fraction(snap_fraction),
    .result       (result)
  );

  // A field without digits always carries a zero value.
  a_empty_is_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.had_digits |-> result.value_milli == 32'sd0)
    else $error("empty field produced a nonzero value");

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result beat present right after reset");

  a_field_held: assert property (@(posedge clk) disable iff (rst)
    snap_valid && !snap_ready |=> snap_valid && $stable(snap_integer))
    else $error("closed field lost while the scaler stalled");

  a_start_match: assert property (@(posedge clk) disable iff (rst)
    start_char |-> stream.in_byte == start_char_reg)
    else $error("start character compare disagrees with register");

endmodule

// File: sim/field_value_checker.sv
module field_value_checker (
  input  logic       clk,
  input  logic       rst,
  asdfp_byte_if      stream,
  asdfp_result_if    result,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  output int         errors,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC_DIGITS = asdfp_pkg::FRACTION_DIGITS_DEFAULT;

  typedef struct packed {
    logic signed [31:0] value;
    logic               had_digits;
  } field_result_t;

  field_result_t expected_fields[$];
  field_result_t want;

  asdfp_pkg::mode_t mode;
  logic [7:0]  start_char;
  logic        neg;
  logic        point;
  logic        seen;
  logic [31:0] int_acc;
  logic [9:0]  frac_acc;
  logic [1:0]  frac_cnt;

  initial begin
    errors = 0;
    pending = 0;
  end

  function automatic logic [63:0] ten_to(input int unsigned n);
    logic [63:0] p;
    p = 64'd1;
    for (int unsigned k = 0; k < n; k++) begin
      p = p * 64'd10;
    end
    return p;
  endfunction

  task automatic clear_field();
    neg = 1'b0;
    point = 1'b0;
    seen = 1'b0;
    int_acc = '0;
    frac_acc = '0;
    frac_cnt = '0;
  endtask

  task automatic close_field();
    logic [63:0]   mag;
    field_result_t r;
    mag = {32'd0, int_acc} * ten_to(FRAC_DIGITS)
        + {54'd0, frac_acc} * ten_to(FRAC_DIGITS - int'(frac_cnt));
    if (neg) begin
      if (mag >= 64'h8000_0000) begin
        r.value = asdfp_pkg::VALUE_MIN;
      end else begin
        r.value = 32'd0 - mag[31:0];
      end
    end else begin
      if (mag > 64'h7FFF_FFFF) begin
        r.value = asdfp_pkg::VALUE_MAX;
      end else begin
        r.value = mag[31:0];
      end
    end
    r.had_digits = seen;
    expected_fields.push_back(r);
    mode = asdfp_pkg::MODE_IDLE;
    clear_field();
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic eop);
    logic        closed;
    logic [63:0] grown;
    closed = 1'b0;
    if (mode != asdfp_pkg::MODE_FIRST && mode != asdfp_pkg::MODE_NUMBER) begin
      mode = asdfp_pkg::MODE_IDLE;
      if (b == start_char) begin
        clear_field();
        mode = asdfp_pkg::MODE_FIRST;
        if (eop) begin
          close_field();
        end
      end
    end else begin
      if (mode == asdfp_pkg::MODE_FIRST && b == asdfp_pkg::ASCII_MINUS) begin
        neg = 1'b1;
        mode = asdfp_pkg::MODE_NUMBER;
      end else if (b >= asdfp_pkg::ASCII_ZERO && b <= asdfp_pkg::ASCII_NINE) begin
        mode = asdfp_pkg::MODE_NUMBER;
        seen = 1'b1;
        if (point) begin
          if (frac_cnt < FRAC_DIGITS) begin
            frac_acc = frac_acc * 10'd10 + 10'(b - asdfp_pkg::ASCII_ZERO);
            frac_cnt = frac_cnt + 2'd1;
          end
        end else begin
          grown = {32'd0, int_acc} * 64'd10 + 64'(b - asdfp_pkg::ASCII_ZERO);
          if (grown > 64'hFFFF_FFFF) begin
            grown = 64'hFFFF_FFFF;
          end
          int_acc = grown[31:0];
        end
      end else if (b == asdfp_pkg::ASCII_POINT) begin
        mode = asdfp_pkg::MODE_NUMBER;
        point = 1'b1;
      end else begin
        close_field();
        closed = 1'b1;
      end
      if (!closed && eop) begin
        close_field();
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_fields.delete();
      start_char = asdfp_pkg::START_CHAR_RESET;
      mode = asdfp_pkg::MODE_IDLE;
      clear_field();
    end else begin
      if (cfg_we) begin
        start_char = cfg_wdata;
      end
      if (result.valid && result.ready) begin
        if (expected_fields.size() == 0) begin
          $display("%0t: unexpected result beat: value_milli %0d had_digits %0b",
                   $time, result.value_milli, result.had_digits);
          errors++;
        end else begin
          want = expected_fields.pop_front();
          if (result.value_milli !== want.value) begin
            $display("%0t: value_milli mismatch: expected %0d, actual %0d",
                     $time, want.value, result.value_milli);
            errors++;
          end
          if (result.had_digits !== want.had_digits) begin
            $display("%0t: had_digits mismatch: expected %0b, actual %0b",
                     $time, want.had_digits, result.had_digits);
            errors++;
          end
        end
      end
      if (stream.valid && stream.ready) begin
        parse_byte(stream.in_byte, stream.end_of_packet);
      end
    end
    pending = expected_fields.size();
  end

  final begin
    if (expected_fields.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_fields.size());
    end
  end

endmodule

// File: sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_BYTES = 290;

  typedef logic [7:0] byte_q_t[$];

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [7:0] cfg_wdata;
  int         error_count;
  int         pending_count;
  int         cycles = 0;
  int         sent_bytes = 0;
  int         burst_left = 0;
  int         stall_phase = 0;
  int         stall_style = 0;

  asdfp_byte_if   byte_ch();
  asdfp_result_if result_ch();

  ascii_signed_decimal_field_parser_core dut (
    .clk       (clk),
    .rst       (rst),
    .stream    (byte_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  field_value_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .stream    (byte_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .errors    (error_count),
    .pending   (pending_count)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase % 200 == 0) begin
      stall_style <= $urandom_range(0, 3);
    end
    case (stall_style)
      0: result_ch.ready <= 1'b1;
      1: result_ch.ready <= ($urandom_range(0, 3) != 0);
      2: result_ch.ready <= (stall_phase % 7 < 4);
      default: result_ch.ready <= 1'($urandom_range(0, 1));
    endcase
  end

  function automatic byte_q_t str_bytes(input string s);
    byte_q_t q;
    for (int i = 0; i < s.len(); i++) begin
      q.push_back(s[i]);
    end
    return q;
  endfunction

  function automatic logic [7:0] noise_byte(input logic [7:0] sc);
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == sc) begin
      b = ~b;
    end
    return b;
  endfunction

  function automatic logic [7:0] digit_char();
    return asdfp_pkg::ASCII_ZERO + 8'($urandom_range(0, 9));
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic eop);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        byte_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    byte_ch.valid <= 1'b1;
    byte_ch.in_byte <= b;
    byte_ch.end_of_packet <= eop;
    do begin
      @(posedge clk);
    end while (!byte_ch.ready);
    @(negedge clk);
    sent_bytes++;
  endtask

  task automatic send_packet(input byte_q_t pkt);
    foreach (pkt[i]) begin
      send_beat(pkt[i], i == pkt.size() - 1);
    end
  endtask

  task automatic drain();
    byte_ch.valid <= 1'b0;
    while (pending_count != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_start_char(input logic [7:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_packet(input logic [7:0] sc);
    byte_q_t    pkt;
    int         fields;
    int         ndig;
    logic [7:0] b;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 8)) begin
        b = ($urandom_range(0, 3) == 0) ? sc : 8'($urandom_range(0, 255));
        pkt.push_back(b);
      end
    end else begin
      repeat ($urandom_range(0, 3)) pkt.push_back(noise_byte(sc));
      fields = $urandom_range(1, 3);
      for (int f = 0; f < fields; f++) begin
        pkt.push_back(sc);
        if ($urandom_range(0, 2) == 0) begin
          pkt.push_back(asdfp_pkg::ASCII_MINUS);
        end
        case ($urandom_range(0, 9))
          0: ndig = $urandom_range(10, 13);
          1, 2: ndig = $urandom_range(5, 8);
          default: ndig = $urandom_range(0, 4);
        endcase
        repeat (ndig) pkt.push_back(digit_char());
        if ($urandom_range(0, 1) == 1) begin
          pkt.push_back(asdfp_pkg::ASCII_POINT);
          repeat ($urandom_range(0, 5)) begin
            if ($urandom_range(0, 9) == 0) begin
              pkt.push_back(asdfp_pkg::ASCII_POINT);
            end
            pkt.push_back(digit_char());
          end
        end
        if (f < fields - 1 || $urandom_range(0, 1) == 1) begin
          do begin
            b = 8'($urandom_range(0, 255));
          end while ((b >= asdfp_pkg::ASCII_ZERO && b <= asdfp_pkg::ASCII_NINE) ||
                     b == asdfp_pkg::ASCII_POINT);
          pkt.push_back(b);
        end
        if (f < fields - 1 && $urandom_range(0, 2) == 0) begin
          pkt.push_back(noise_byte(sc));
        end
      end
    end
    send_packet(pkt);
  endtask

  initial begin
    byte_q_t    q;
    logic [7:0] phase_chars[5];
    int         target;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 8'd0;
    byte_ch.valid = 1'b0;
    byte_ch.in_byte = 8'd0;
    byte_ch.end_of_packet = 1'b0;
    result_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    q.delete();
    q.push_back(8'h00);
    send_packet(q);
    send_packet(str_bytes(":"));
    send_packet(str_bytes(":-"));
    q = str_bytes(":1.2.3456-");
    q.push_back(8'hFF);
    send_packet(q);
    send_packet(str_bytes(":99999999999"));

    phase_chars[0] = 8'h00;
    phase_chars[1] = 8'hFF;
    phase_chars[2] = 8'($urandom_range(0, 255));
    phase_chars[3] = asdfp_pkg::START_CHAR_RESET;
    phase_chars[4] = 8'($urandom_range(0, 255));
    foreach (phase_chars[p]) begin
      write_start_char(phase_chars[p]);
      target = sent_bytes + PHASE_BYTES;
      while (sent_bytes < target) begin
        random_packet(phase_chars[p]);
      end
    end

    drain();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
